// ----- hw/rtl/chacha20_stream_cipher_defines.svh -----
// Assertion macros for the ChaCha20 stream cipher.
// Used by the top level only; no other dependencies.
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CC_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define CC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ----- hw/rtl/cc20_pkg.sv -----
// Shared types, constants and functions for the ChaCha20 stream cipher.
// No dependencies.
package cc20_pkg;

   localparam int DoubleRoundsDefault = 10;
   localparam int QueueDepthDefault   = 2;

   localparam logic [31:0] Sigma0 = 32'h61707865;
   localparam logic [31:0] Sigma1 = 32'h3320646e;
   localparam logic [31:0] Sigma2 = 32'h79622d32;
   localparam logic [31:0] Sigma3 = 32'h6b206574;

   // Register indexes
   localparam logic [2:0] RegKey0   = 3'd0;
   localparam logic [2:0] RegKey1   = 3'd1;
   localparam logic [2:0] RegKey2   = 3'd2;
   localparam logic [2:0] RegKey3   = 3'd3;
   localparam logic [2:0] RegNonceL = 3'd4;
   localparam logic [2:0] RegNonceH = 3'd5;

   // One classified word handed from front to back
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last;
      logic [31:0] mask;
   } word_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

   // Byte mask from the valid byte count; counts above four mean four
   function automatic logic [31:0] byte_mask(input logic [2:0] vb);
      logic [31:0] m;
      m = 32'h0;
      case (vb)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      byte_mask = m;
   endfunction

endpackage

// ----- hw/rtl/chacha20_stream_cipher.sv -----
// ChaCha20 stream cipher: one 32-bit word in, one XORed word out. A word that
// finds no keystream block ready starts a block: the initial state is loaded,
// the four-quarter-round unit runs 2*DOUBLE_ROUNDS rounds and the final add
// stores the keystream; the other 15 words of a full block use it directly.
// A two-word queue decouples request intake from the keystream back end. The
// block counter restarts at 1 on any key or nonce write. Depends on cc20_pkg,
// cc20_front, cc20_back and chacha20_stream_cipher_defines.svh.
`include "chacha20_stream_cipher_defines.svh"
module chacha20_stream_cipher import cc20_pkg::*; #(
   parameter int DOUBLE_ROUNDS = DoubleRoundsDefault,
   parameter int QUEUE_DEPTH   = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_data_out,
   output logic [2:0]  rsp_out_valid_bytes,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [255:0] key_ff;
   logic [95:0]  nonce_ff;
   logic         restart;
   logic         q_valid, q_pop, busy;
   word_type     q_word;

   assign csr_ready = 1'b1;

   // Write key and nonce registers; restart stream on a valid index
   always_comb begin
      restart = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            RegKey0, RegKey1, RegKey2, RegKey3, RegNonceL, RegNonceH: restart = 1'b1;
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         nonce_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            RegKey0:   key_ff[63:0]    <= csr_data;
            RegKey1:   key_ff[127:64]  <= csr_data;
            RegKey2:   key_ff[191:128] <= csr_data;
            RegKey3:   key_ff[255:192] <= csr_data;
            RegNonceL: nonce_ff[63:0]  <= csr_data;
            RegNonceH: nonce_ff[95:64] <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   cc20_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_word, .req_valid_bytes,
      .req_end_of_message, .q_valid, .q_word, .q_pop
   );

   cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
      .clock, .reset, .key(key_ff), .nonce(nonce_ff), .restart, .q_valid, .q_word,
      .q_pop, .rsp_valid, .rsp_stall, .rsp_data_out, .rsp_out_valid_bytes,
      .rsp_out_last, .busy
   );

   `CC_ASSERT_IMPL(a_pop_needs_word, clock, reset, q_pop, q_valid,
      "queue popped while empty")
   `CC_ASSERT_NEXT(a_result_shown, clock, reset, q_pop, rsp_valid,
      "consumed word produced no result")
   `CC_ASSERT_IMPL(a_unused_bytes_zero, clock, reset,
      rsp_valid && rsp_out_valid_bytes == 3'd1, rsp_data_out[31:8] == 24'h0,
      "unused output bytes not zero")
   `CC_ASSERT_IMPL(a_csr_when_idle, clock, reset, csr_valid, !busy,
      "register written with words in flight")

endmodule

// ----- hw/rtl/cc20_front.sv -----
// Front end: accepts request words, computes their byte masks and queues them.
// Depends on cc20_pkg.
module cc20_front import cc20_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_end_of_message,
   output logic        q_valid,
   output word_type    q_word,
   input  logic        q_pop
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   word_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            push;

   assign req_stall = (cnt_ff == CW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_word    = slot_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the classified word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= '{data_word: req_data_word, valid_bytes: req_valid_bytes,
                             last: req_end_of_message,
                             mask: byte_mask(req_valid_bytes)};
      end
   end

endmodule

// ----- hw/rtl/cc20_back.sv -----
// Back end: keystream block generator (four quarter rounds a cycle) and word XOR.
// Depends on cc20_pkg.
module cc20_back import cc20_pkg::*; #(
   parameter int DOUBLE_ROUNDS = DoubleRoundsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [255:0] key,
   input  logic [95:0]  nonce,
   input  logic         restart,
   input  logic         q_valid,
   input  word_type     q_word,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_data_out,
   output logic [2:0]   rsp_out_valid_bytes,
   output logic         rsp_out_last,
   output logic         busy
);
   localparam int HW = $clog2(2 * DOUBLE_ROUNDS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL} state_enum_type;

   state_enum_type  st_ff;
   logic [HW-1:0]   half_ff;
   logic            ready_ff;
   logic [3:0]      pos_ff;
   logic [31:0]     ctr_ff;
   logic [31:0]     ws_ff [16];
   logic [31:0]     ks_ff [16];
   logic [31:0]     init [16];
   logic [31:0]     nx [16];
   logic            out_ok;
   logic            use_word;

   // Initial state from constants, key, counter and nonce
   always_comb begin
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int i = 0; i < 8; i++) begin
         init[4 + i] = key[32*i +: 32];
      end
      init[12] = ctr_ff;
      init[13] = nonce[31:0];
      init[14] = nonce[63:32];
      init[15] = nonce[95:64];
   end

   // One column or diagonal round: four quarter rounds in parallel
   always_comb begin
      logic [31:0] a, b, c, d;
      int ia, ib, ic, id;
      for (int i = 0; i < 16; i++) nx[i] = ws_ff[i];
      for (int j = 0; j < 4; j++) begin
         ia = j;
         ib = half_ff[0] ? 4 + ((j + 1) % 4) : 4 + j;
         ic = half_ff[0] ? 8 + ((j + 2) % 4) : 8 + j;
         id = half_ff[0] ? 12 + ((j + 3) % 4) : 12 + j;
         a = ws_ff[ia]; b = ws_ff[ib]; c = ws_ff[ic]; d = ws_ff[id];
         a = a + b; d = rotl(d ^ a, 16);
         c = c + d; b = rotl(b ^ c, 12);
         a = a + b; d = rotl(d ^ a, 8);
         c = c + d; b = rotl(b ^ c, 7);
         nx[ia] = a; nx[ib] = b; nx[ic] = c; nx[id] = d;
      end
   end

   assign out_ok   = !rsp_valid || !rsp_stall;
   assign use_word = (st_ff == ST_IDLE) && q_valid && ready_ff && out_ok;
   assign q_pop    = use_word;
   assign busy     = (st_ff != ST_IDLE) || q_valid || rsp_valid;

   // Sequence block generation, consume words, hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         half_ff   <= '0;
         ready_ff  <= 1'b0;
         pos_ff    <= '0;
         ctr_ff    <= 32'd1;
         rsp_valid <= 1'b0;
      end else begin
         // Load a new result word, or drop the one taken
         if (use_word) begin
            rsp_valid           <= 1'b1;
            rsp_data_out        <= (q_word.data_word ^ ks_ff[pos_ff]) & q_word.mask;
            rsp_out_valid_bytes <= q_word.valid_bytes;
            rsp_out_last        <= q_word.last;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         // Track block readiness, word position and counter
         if (restart) begin
            ctr_ff   <= 32'd1;
            ready_ff <= 1'b0;
            pos_ff   <= '0;
         end else if (use_word) begin
            if (pos_ff == 4'd15 || q_word.last) begin
               ready_ff <= 1'b0;
               pos_ff   <= '0;
               ctr_ff   <= ctr_ff + 1'b1;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end else if (st_ff == ST_FINAL) begin
            ready_ff <= 1'b1;
            pos_ff   <= '0;
         end
         unique case (st_ff)
            ST_IDLE: begin
               if (q_valid && !ready_ff && !restart) begin
                  for (int i = 0; i < 16; i++) ws_ff[i] <= init[i];
                  half_ff <= '0;
                  st_ff   <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               for (int i = 0; i < 16; i++) ws_ff[i] <= nx[i];
               half_ff <= half_ff + 1'b1;
               if (half_ff == HW'(2 * DOUBLE_ROUNDS - 1)) begin
                  st_ff <= ST_FINAL;
               end
            end
            ST_FINAL: begin
               for (int i = 0; i < 16; i++) ks_ff[i] <= ws_ff[i] + init[i];
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- bench/tb_chacha20_stream_cipher.sv -----
// Self-checking bench for the ChaCha20 stream cipher: random message words,
// key and nonce phases, a scoreboard class with its own keystream predictor.
// Depends on cc20_pkg and the chacha20_stream_cipher RTL.
`timescale 1ns / 100ps
module tb_chacha20_stream_cipher import cc20_pkg::*; ();

   localparam int CycleLimit = 400000;

   // Predicts the XORed words and checks them in order
   class cipher_scoreboard;
      logic [63:0] key_regs [4];
      logic [63:0] nonce_lo;
      logic [31:0] nonce_hi;
      logic [31:0] ks_words [16];
      logic [3:0]  word_pos;
      bit          have_block;
      logic [31:0] blk_count;
      logic [31:0] exp_data [$];
      logic [2:0]  exp_vb [$];
      logic        exp_last [$];
      int          mismatches;

      function new();
         for (int i = 0; i < 4; i++) key_regs[i] = '0;
         nonce_lo = '0;
         nonce_hi = '0;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         blk_count = 32'd1;
         have_block = 0;
         word_pos = '0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            RegKey0:   key_regs[0] = val;
            RegKey1:   key_regs[1] = val;
            RegKey2:   key_regs[2] = val;
            RegKey3:   key_regs[3] = val;
            RegNonceL: nonce_lo = val;
            RegNonceH: nonce_hi = val[31:0];
            default:   return;
         endcase
         restart();
      endfunction

      function logic [31:0] rot(logic [31:0] v, int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function void quarter(ref logic [31:0] w [16], input int a, int b, int c, int d);
         w[a] += w[b]; w[d] = rot(w[d] ^ w[a], 16);
         w[c] += w[d]; w[b] = rot(w[b] ^ w[c], 12);
         w[a] += w[b]; w[d] = rot(w[d] ^ w[a], 8);
         w[c] += w[d]; w[b] = rot(w[b] ^ w[c], 7);
      endfunction

      function void build_block();
         logic [31:0] init [16];
         logic [31:0] w [16];
         init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
         for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = key_regs[i][31:0];
            init[5 + 2 * i] = key_regs[i][63:32];
         end
         init[12] = blk_count;
         init[13] = nonce_lo[31:0];
         init[14] = nonce_lo[63:32];
         init[15] = nonce_hi;
         w = init;
         for (int r = 0; r < DoubleRoundsDefault; r++) begin
            quarter(w, 0, 4, 8, 12);  quarter(w, 1, 5, 9, 13);
            quarter(w, 2, 6, 10, 14); quarter(w, 3, 7, 11, 15);
            quarter(w, 0, 5, 10, 15); quarter(w, 1, 6, 11, 12);
            quarter(w, 2, 7, 8, 13);  quarter(w, 3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
         have_block = 1;
         word_pos = '0;
      endfunction

      // Note an accepted word and queue its expected ciphertext
      function void note_word(logic [31:0] d, logic [2:0] vb, logic eom);
         logic [31:0] ks;
         logic [31:0] m;
         if (!have_block) build_block();
         ks = ks_words[word_pos];
         word_pos = word_pos + 4'd1;
         if (word_pos == 0 || eom) begin
            have_block = 0;
            word_pos = '0;
            blk_count = blk_count + 32'd1;
         end
         case (vb)
            3'd0: m = 32'h0000_0000;
            3'd1: m = 32'h0000_00ff;
            3'd2: m = 32'h0000_ffff;
            3'd3: m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
         endcase
         exp_data.push_back((d ^ ks) & m);
         exp_vb.push_back(vb);
         exp_last.push_back(eom);
      endfunction

      // Compare a result word against the oldest expectation
      function void check_word(logic [31:0] d, logic [2:0] vb, logic eom);
         logic [31:0] ed;
         logic [2:0]  ev;
         logic        el;
         if (exp_data.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", d);
            return;
         end
         ed = exp_data.pop_front();
         ev = exp_vb.pop_front();
         el = exp_last.pop_front();
         if (d !== ed || vb !== ev || eom !== el) begin
            mismatches++;
            if (mismatches <= 10)
               $display("word mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                        ed, ev, el, d, vb, eom);
         end
      endfunction

      function int pending();
         return exp_data.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_valid_bytes = 3'd4;
   logic        req_end_of_message = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_data_out;
   logic [2:0]  rsp_out_valid_bytes;
   logic        rsp_out_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   cipher_scoreboard sb = new();
   int  cycles = 0;
   bit  calm = 0;
   bit  hold_off = 0;

   chacha20_stream_cipher DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Count cycles and end a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Check results at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_data_out, rsp_out_valid_bytes, rsp_out_last);
   end

   // Stall the result side at random, or hold off for a long stretch
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1;
            for (n = 0; n < 300; n++) @(negedge clock);
            hold_off = 0;
         end
         rsp_stall <= !calm && ($urandom_range(99) < 13);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Offer one word; valid stays high across back-to-back words
   task automatic send_word(logic [31:0] d, logic [2:0] vb, logic eom);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data_word <= d;
      req_valid_bytes <= vb;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(d, vb, eom);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_message(int len);
      logic [2:0] vb;
      for (int i = 0; i < len; i++) begin
         vb = (i == len - 1) ? 3'($urandom_range(4, 1)) : 3'd4;
         if ($urandom_range(99) < 3) vb = 3'($urandom_range(7));
         send_word($urandom, vb, i == len - 1);
      end
   endtask

   task automatic random_keys();
      for (int r = 0; r < 6; r++)
         write_reg(3'(r), {$urandom, $urandom});
   endtask

   initial begin
      int sent;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Zero key, then the all-ones extremes
      send_word(32'h0, 3'd4, 0);
      send_word(32'hffff_ffff, 3'd4, 0);
      send_word(32'h1234_5678, 3'd1, 0);
      send_word(32'hffff_ffff, 3'd0, 0);
      send_word(32'hffff_ffff, 3'd7, 0);
      send_word(32'haaaa_5555, 3'd3, 1);
      for (int i = 0; i < 17; i++) send_word($urandom, 3'd4, 0);
      send_word($urandom, 3'd2, 1);
      drain();
      for (int r = 0; r < 5; r++) write_reg(3'(r), '1);
      write_reg(RegNonceH, 64'hffff_ffff);
      write_reg(3'd6, 64'h0);
      write_reg(3'd7, 64'h5);
      send_message(20);
      drain();

      // Random phases with calm and pressure stretches
      sent = 0;
      for (int ph = 0; sent < 1400; ph++) begin
         random_keys();
         calm = (ph == 2);
         if (ph == 3) hold_off = 1;
         for (int m = 0; m < 10; m++) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
            send_message(len);
            sent += len;
         end
         drain();
      end
      calm = 0;
      drain();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
